// ----- sv/frcd_pkg.sv -----
// Package for the fractional row clock divider.
// Holds field widths, the controller state type and the command and status structs.
// No dependencies.
package frcd_pkg;

    localparam int unsigned TprW   = 8;
    localparam int unsigned RegW   = 8;
    localparam int unsigned RowsW  = 8;
    localparam int unsigned AccW   = 17;
    localparam int unsigned ProdW  = AccW + TprW;
    localparam int unsigned ThrW   = RegW + TprW;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_NUMERATOR   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DENOMINATOR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RSC_START,
        ST_RSC_WAIT,
        ST_RECORD,
        ST_ROW_START,
        ST_ROW_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rsc_mul;
        logic rsc_wr;
        logic record;
        logic start_set;
        logic zero_res;
        logic row_mul;
        logic div_start;
        logic row_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic disabled;
        logic need_rescale;
        logic started;
        logic div_busy;
        logic div_done;
    } t_sts;

endpackage

// ----- sv/frcd_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
// Generic widths; used by the fractional row clock divider datapath. No dependencies.
module frcd_div #(
    parameter int unsigned DVD_W = 25,
    parameter int unsigned DVS_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DVD_W-1:0]             i_dividend,
    input  logic [DVS_W-1:0]             i_divisor,
    output logic [2*((DVD_W+1)/2)-1:0]   o_quotient,
    output logic [DVS_W-1:0]             o_remainder,
    output logic                         o_busy,
    output logic                         o_done
);

    localparam int unsigned Steps = (DVD_W + 1) / 2;
    localparam int unsigned PadW  = 2 * Steps;
    localparam int unsigned CntW  = (Steps > 1) ? $clog2(Steps) : 1;

    logic [PadW-1:0]  r_dvd, n_dvd;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    // Two dependent shift-compare-subtract steps; the quotient bits shift into the
    // dividend register as its bits move out into the remainder.
    always_comb begin
        logic [DVS_W:0] v_trial;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int i = 0; i < 2; i++) begin
            v_trial = {n_rem, n_dvd[PadW-1]};
            n_dvd   = {n_dvd[PadW-2:0], 1'b0};
            if (v_trial >= {1'b0, r_dvs}) begin
                v_trial  = v_trial - {1'b0, r_dvs};
                n_dvd[0] = 1'b1;
            end
            n_rem = v_trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(Steps - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PadW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;
    assign o_busy      = r_busy;
    assign o_done      = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider reports done while still busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == '0 |=> r_done)
        else $error("divider missed its done pulse");

endmodule

// ----- sv/frcd_dp.sv -----
// Datapath of the fractional row clock divider: configuration registers, phase state,
// multiplies, the shared divider and the result register. Uses frcd_pkg and frcd_div.
module frcd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frcd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [frcd_pkg::RegW-1:0]     i_cfg_data,
    input  logic [frcd_pkg::TprW-1:0]     i_tpr,
    input  frcd_pkg::t_cmd                i_cmd,
    output frcd_pkg::t_sts                o_sts,
    output logic [frcd_pkg::RowsW-1:0]    o_rows
);
    import frcd_pkg::*;

    localparam int unsigned QuoW = 2 * ((ProdW + 1) / 2);

    logic [RegW-1:0]  r_num;
    logic [RegW-1:0]  r_den;
    logic [AccW-1:0]  r_acc, n_acc;
    logic [TprW-1:0]  r_prev;
    logic             r_started;
    logic [TprW-1:0]  r_tpr;
    logic [ProdW-1:0] r_prod;
    logic [ThrW-1:0]  r_dvs;
    logic [RowsW-1:0] r_res;
    logic [RowsW-1:0] r_out;

    logic [QuoW-1:0]  w_quo;
    logic [ThrW-1:0]  w_rem;
    logic             w_busy;
    logic             w_done;

    frcd_div #(
        .DVD_W (ProdW),
        .DVS_W (ThrW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_prod),
        .i_divisor   (r_dvs),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_busy      (w_busy),
        .o_done      (w_done)
    );

    // The rescaled phase saturates at the largest accumulator value.
    always_comb begin
        n_acc = r_acc;
        if (i_cmd.rsc_wr) begin
            n_acc = (|w_quo[QuoW-1:AccW]) ? {AccW{1'b1}} : w_quo[AccW-1:0];
        end else if (i_cmd.row_wr) begin
            n_acc = AccW'(w_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num     <= RegW'(1);
            r_den     <= RegW'(1);
            r_acc     <= '0;
            r_prev    <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUMERATOR:   r_num <= i_cfg_data;
                    CFG_DENOMINATOR: r_den <= i_cfg_data;
                    default: ;
                endcase
            end
            r_acc <= n_acc;
            if (i_cmd.record) begin
                r_prev <= r_tpr;
            end
            if (i_cmd.start_set) begin
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tpr <= (i_tpr == '0) ? TprW'(1) : i_tpr;
        end
        if (i_cmd.rsc_mul) begin
            r_prod <= ProdW'(r_acc) * ProdW'(r_tpr);
            r_dvs  <= ThrW'(r_prev);
        end else if (i_cmd.row_mul) begin
            r_prod <= ProdW'({1'b0, r_acc} + {{(AccW+1-RegW){1'b0}}, r_num});
            r_dvs  <= ThrW'(r_den) * ThrW'(r_tpr);
        end
        if (i_cmd.zero_res) begin
            r_res <= '0;
        end else if (i_cmd.row_wr) begin
            r_res <= (|w_quo[QuoW-1:RowsW]) ? {RowsW{1'b1}} : w_quo[RowsW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.disabled     = (r_num == '0) || (r_den == '0);
    assign o_sts.need_rescale = (r_prev != '0) && (r_prev != r_tpr);
    assign o_sts.started      = r_started;
    assign o_sts.div_busy     = w_busy;
    assign o_sts.div_done     = w_done;
    assign o_rows             = r_out;

    a_acc_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_wr |=> ({1'b0, r_acc} < {2'b0, r_dvs}))
        else $error("phase left at or above the row threshold");

    a_prev_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.record |=> (r_prev != '0))
        else $error("recorded ticks per row is zero");

endmodule

// ----- sv/frcd_ctrl.sv -----
// Controller of the fractional row clock divider: sequences one item through the
// datapath and owns the handshakes. Uses frcd_pkg.
module frcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  frcd_pkg::t_sts  i_sts,
    output frcd_pkg::t_cmd  o_cmd
);
    import frcd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.disabled) begin
                    o_cmd.zero_res = 1'b1;
                    n_state        = ST_OUT;
                end else if (i_sts.need_rescale) begin
                    o_cmd.rsc_mul = 1'b1;
                    n_state       = ST_RSC_START;
                end else begin
                    n_state = ST_RECORD;
                end
            end
            ST_RSC_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_RSC_WAIT;
            end
            ST_RSC_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.rsc_wr = 1'b1;
                    n_state      = ST_RECORD;
                end
            end
            ST_RECORD: begin
                o_cmd.record = 1'b1;
                // The first counting tick only records the row length.
                if (!i_sts.started) begin
                    o_cmd.start_set = 1'b1;
                    o_cmd.zero_res  = 1'b1;
                    n_state         = ST_OUT;
                end else begin
                    o_cmd.row_mul = 1'b1;
                    n_state       = ST_ROW_START;
                end
            end
            ST_ROW_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.row_wr = 1'b1;
                    n_state      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

// ----- sv/fractional_row_clock_divider.sv -----
// Top level of the fractional row clock divider.
// Joins controller frcd_ctrl and datapath frcd_dp; uses frcd_pkg.
//
// Each input item on the s_axis channel is one sequencer tick carrying the
// current ticks per row. For every item exactly one result item leaves on the
// m_axis channel with the number of row boundaries crossed on that tick.
// The configuration port writes the rate numerator (index 0) and the rate
// denominator (index 1); write only while the block is idle.
//
// The shared divider produces two quotient bits per cycle and runs once for
// the phase rescale, only when the row length changes, and once for the row
// count, not when counting is disabled or on the first tick. One item is in
// work at a time; the next item can be accepted once the previous one has
// reached the output register. Reset restores numerator and denominator to 1,
// clears the phase and forgets the recorded row length. If the receiver
// stalls, the result holds in the output register; the next item may still be
// taken and worked on, and then waits until that register is free.
module fractional_row_clock_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frcd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [frcd_pkg::RegW-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] ticks_per_row
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata    // [7:0] rows_advanced
);
    import frcd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    frcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    frcd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tpr      (s_axis_tdata[TprW-1:0]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_rows     (m_axis_tdata[RowsW-1:0])
    );

endmodule
